[design/skm_pkg.sv]
// ----------------------------------------------------------------------------
// skm_pkg
// Shared types and constants for the scan code keymap with auto-repeat.
// ----------------------------------------------------------------------------
package skm_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	localparam logic [1:0] REQ_POLL = 2'd0;
	localparam logic [1:0] REQ_KEY  = 2'd1;
	localparam logic [1:0] REQ_AUX  = 2'd2;

	localparam logic [1:0] CFG_DELAY  = 2'd0;
	localparam logic [1:0] CFG_PERIOD = 2'd1;
	localparam logic [1:0] CFG_WINDOW = 2'd2;

	localparam logic [31:0] DELAY_RST  = 32'd385000000;
	localparam logic [31:0] PERIOD_RST = 32'd55000000;
	localparam logic [31:0] WINDOW_RST = 32'd275000000;

	localparam logic [7:0] SC_PREFIX   = 8'hE0;
	localparam logic [7:0] SC_LSHIFT   = 8'h2A;
	localparam logic [7:0] SC_RSHIFT   = 8'h36;
	localparam logic [7:0] SC_CTRL     = 8'h1D;
	localparam logic [7:0] SC_CAPS     = 8'h3A;
	localparam logic [7:0] SC_F12      = 8'h58;
	localparam logic [7:0] SC_CTRL_BRK = 8'h9D;
	localparam logic [7:0] SC_UP       = 8'h48;
	localparam logic [7:0] SC_DOWN     = 8'h50;
	localparam logic [7:0] SC_LEFT     = 8'h4B;
	localparam logic [7:0] SC_RIGHT    = 8'h4D;
	localparam logic [7:0] SC_PGUP     = 8'h49;
	localparam logic [7:0] SC_PGDN     = 8'h51;
	localparam logic [7:0] SC_HOME     = 8'h47;
	localparam logic [7:0] SC_END      = 8'h4F;
	localparam logic [7:0] SC_DEL      = 8'h53;

	localparam logic [7:0] KEY_NONE     = 8'h00;
	localparam logic [7:0] KEY_ARROW_UP = 8'h80;
	localparam logic [7:0] KEY_ARROW_DN = 8'h81;
	localparam logic [7:0] KEY_ARROW_LT = 8'h82;
	localparam logic [7:0] KEY_ARROW_RT = 8'h83;
	localparam logic [7:0] KEY_PAGE_UP  = 8'h84;
	localparam logic [7:0] KEY_PAGE_DN  = 8'h85;
	localparam logic [7:0] KEY_START    = 8'h86;
	localparam logic [7:0] KEY_END      = 8'h87;
	localparam logic [7:0] KEY_DEL      = 8'h88;
	localparam logic [7:0] KEY_SCRUP    = 8'h89;
	localparam logic [7:0] KEY_SCRDN    = 8'h8A;
	localparam logic [7:0] KEY_F12      = 8'h8B;

	localparam logic [7:0] ASCII_LA   = 8'h61;
	localparam logic [7:0] ASCII_LZ   = 8'h7A;
	localparam logic [7:0] ASCII_UA   = 8'h41;
	localparam logic [7:0] ASCII_UZ   = 8'h5A;
	localparam logic [7:0] CASE_BIT   = 8'h20;
	localparam logic [7:0] LOWER_BASE = 8'h60;
	localparam logic [7:0] UPPER_BASE = 8'h40;

	typedef enum logic [1:0] {
		OP_EMIT,
		OP_POLL,
		OP_PRESS,
		OP_RELEASE
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [6:0]  scan;
		logic        ext;
		logic [7:0]  code;
		logic [47:0] now;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [7:0] plain_map(input logic [6:0] sc);
		logic [7:0] c;
		case (sc)
			7'h01: c = 8'h1B;
			7'h02: c = 8'h31;
			7'h03: c = 8'h32;
			7'h04: c = 8'h33;
			7'h05: c = 8'h34;
			7'h06: c = 8'h35;
			7'h07: c = 8'h36;
			7'h08: c = 8'h37;
			7'h09: c = 8'h38;
			7'h0A: c = 8'h39;
			7'h0B: c = 8'h30;
			7'h0C: c = 8'h2D;
			7'h0D: c = 8'h3D;
			7'h0E: c = 8'h08;
			7'h0F: c = 8'h09;
			7'h10: c = 8'h71;
			7'h11: c = 8'h77;
			7'h12: c = 8'h65;
			7'h13: c = 8'h72;
			7'h14: c = 8'h74;
			7'h15: c = 8'h79;
			7'h16: c = 8'h75;
			7'h17: c = 8'h69;
			7'h18: c = 8'h6F;
			7'h19: c = 8'h70;
			7'h1A: c = 8'h5B;
			7'h1B: c = 8'h5D;
			7'h1C: c = 8'h0A;
			7'h1E: c = 8'h61;
			7'h1F: c = 8'h73;
			7'h20: c = 8'h64;
			7'h21: c = 8'h66;
			7'h22: c = 8'h67;
			7'h23: c = 8'h68;
			7'h24: c = 8'h6A;
			7'h25: c = 8'h6B;
			7'h26: c = 8'h6C;
			7'h27: c = 8'h3B;
			7'h28: c = 8'h27;
			7'h29: c = 8'h60;
			7'h2B: c = 8'h5C;
			7'h2C: c = 8'h7A;
			7'h2D: c = 8'h78;
			7'h2E: c = 8'h63;
			7'h2F: c = 8'h76;
			7'h30: c = 8'h62;
			7'h31: c = 8'h6E;
			7'h32: c = 8'h6D;
			7'h33: c = 8'h2C;
			7'h34: c = 8'h2E;
			7'h35: c = 8'h2F;
			7'h37: c = 8'h2A;
			7'h39: c = 8'h20;
			default: c = KEY_NONE;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] shifted_map(input logic [6:0] sc);
		logic [7:0] c;
		case (sc)
			7'h01: c = 8'h1B;
			7'h02: c = 8'h21;
			7'h03: c = 8'h40;
			7'h04: c = 8'h23;
			7'h05: c = 8'h24;
			7'h06: c = 8'h25;
			7'h07: c = 8'h5E;
			7'h08: c = 8'h26;
			7'h09: c = 8'h2A;
			7'h0A: c = 8'h28;
			7'h0B: c = 8'h29;
			7'h0C: c = 8'h5F;
			7'h0D: c = 8'h2B;
			7'h0E: c = 8'h08;
			7'h0F: c = 8'h09;
			7'h10: c = 8'h51;
			7'h11: c = 8'h57;
			7'h12: c = 8'h45;
			7'h13: c = 8'h52;
			7'h14: c = 8'h54;
			7'h15: c = 8'h59;
			7'h16: c = 8'h55;
			7'h17: c = 8'h49;
			7'h18: c = 8'h4F;
			7'h19: c = 8'h50;
			7'h1A: c = 8'h7B;
			7'h1B: c = 8'h7D;
			7'h1C: c = 8'h0A;
			7'h1E: c = 8'h41;
			7'h1F: c = 8'h53;
			7'h20: c = 8'h44;
			7'h21: c = 8'h46;
			7'h22: c = 8'h47;
			7'h23: c = 8'h48;
			7'h24: c = 8'h4A;
			7'h25: c = 8'h4B;
			7'h26: c = 8'h4C;
			7'h27: c = 8'h3A;
			7'h28: c = 8'h22;
			7'h29: c = 8'h7E;
			7'h2B: c = 8'h7C;
			7'h2C: c = 8'h5A;
			7'h2D: c = 8'h58;
			7'h2E: c = 8'h43;
			7'h2F: c = 8'h56;
			7'h30: c = 8'h42;
			7'h31: c = 8'h4E;
			7'h32: c = 8'h4D;
			7'h33: c = 8'h3C;
			7'h34: c = 8'h3E;
			7'h35: c = 8'h3F;
			7'h37: c = 8'h2A;
			7'h39: c = 8'h20;
			default: c = KEY_NONE;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] ext_map(input logic [7:0] e, input logic shift);
		logic [7:0] c;
		case (e)
			SC_UP:    c = shift ? KEY_SCRUP : KEY_ARROW_UP;
			SC_DOWN:  c = shift ? KEY_SCRDN : KEY_ARROW_DN;
			SC_LEFT:  c = KEY_ARROW_LT;
			SC_RIGHT: c = KEY_ARROW_RT;
			SC_PGUP:  c = KEY_PAGE_UP;
			SC_PGDN:  c = KEY_PAGE_DN;
			SC_HOME:  c = KEY_START;
			SC_END:   c = KEY_END;
			SC_DEL:   c = KEY_DEL;
			default:  c = KEY_NONE;
		endcase
		return c;
	endfunction

endpackage

[design/scancode_keymap_with_autorepeat.sv]
// ----------------------------------------------------------------------------
// scancode_keymap_with_autorepeat
// Scan code set 1 decoder with modifier tracking and timed key repeat.
// ----------------------------------------------------------------------------
// Every accepted request (poll, keyboard byte or aux byte) yields exactly one
// key_code, in order; 0 means nothing. The block takes one request per cycle
// while in_stall is low: the front decodes in the accept cycle, the back
// retires one operation per cycle into the output register unless out_stall
// holds it back. A two-entry queue sits between the two; in_stall rises
// only when that queue is full, which with a request every cycle happens
// in the cycle after out_stall first holds a result back. Times are taken
// modulo 2^TIME_BITS and compared by wrapping difference. Write the repeat
// and release registers only while idle.
module scancode_keymap_with_autorepeat import skm_pkg::*; #(
	parameter int TIME_BITS = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  scan_byte,
	input  logic [47:0] now,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  key_code,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	q_status_t q_stat;
	op_t       front_op;
	op_t       head;
	logic      push;
	logic      pop;

	assign in_stall = q_stat.full;

	skm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.scan_byte(scan_byte),
		.now      (now),
		.q_stat   (q_stat),
		.push     (push),
		.op       (front_op)
	);

	skm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_op(front_op),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	skm_back #(
		.TIME_BITS(TIME_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.key_code (key_code)
	);

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !q_stat.empty)
		else $error("accepted request did not reach the queue");

	a_out_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pop))
		else $error("result appeared without a queue pop");

	a_special_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_code[7] |-> key_code <= KEY_F12)
		else $error("key code outside the special key range");

	a_pop_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty && (!out_valid || !out_stall))
		else $error("queue popped while output register blocked");

endmodule

[design/skm_front.sv]
// ----------------------------------------------------------------------------
// skm_front
// Accepts requests, tracks shift, ctrl, caps and the E0 prefix, and turns
// each request into one operation for the hold and repeat logic.
// ----------------------------------------------------------------------------
module skm_front import skm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [1:0]  req_type,
	input  logic [7:0]  scan_byte,
	input  logic [47:0] now,
	input  q_status_t   q_stat,
	output logic        push,
	output op_t         op
);

	logic       shift_q, ctrl_q, caps_q, prefix_q;
	logic       shift_d, ctrl_d, caps_d, prefix_d;
	logic [7:0] raw_ch, case_ch, ext_code;
	logic       is_lower, is_upper;

	assign push = in_valid && !q_stat.full;

	always_comb begin
		raw_ch   = shift_q ? shifted_map(scan_byte[6:0]) : plain_map(scan_byte[6:0]);
		is_lower = raw_ch inside {[ASCII_LA:ASCII_LZ]};
		is_upper = raw_ch inside {[ASCII_UA:ASCII_UZ]};
		case_ch  = raw_ch;
		if (caps_q && is_lower) begin
			case_ch = raw_ch - CASE_BIT;
		end else if (caps_q && is_upper) begin
			case_ch = raw_ch + CASE_BIT;
		end
		ext_code = ext_map(scan_byte, shift_q);
	end

	always_comb begin
		op.kind  = OP_EMIT;
		op.scan  = scan_byte[6:0];
		op.ext   = 1'b0;
		op.code  = KEY_NONE;
		op.now   = now;
		shift_d  = shift_q;
		ctrl_d   = ctrl_q;
		caps_d   = caps_q;
		prefix_d = prefix_q;
		case (req_type)
			REQ_POLL: begin
				op.kind = OP_POLL;
			end
			REQ_KEY: begin
				if (prefix_q) begin
					prefix_d = 1'b0;
					if (scan_byte == SC_CTRL) begin
						ctrl_d = 1'b1;
					end else if (scan_byte[7]) begin
						if (scan_byte == SC_CTRL_BRK) begin
							ctrl_d = 1'b0;
						end
						op.kind = OP_RELEASE;
						op.ext  = 1'b1;
					end else if (ext_code != KEY_NONE) begin
						op.kind = OP_PRESS;
						op.ext  = 1'b1;
						op.code = ext_code;
					end
				end else if (scan_byte == SC_PREFIX) begin
					prefix_d = 1'b1;
				end else if (scan_byte[7]) begin
					if ({1'b0, scan_byte[6:0]} inside {SC_LSHIFT, SC_RSHIFT}) begin
						shift_d = 1'b0;
					end
					if ({1'b0, scan_byte[6:0]} == SC_CTRL) begin
						ctrl_d = 1'b0;
					end
					op.kind = OP_RELEASE;
				end else if (scan_byte inside {SC_LSHIFT, SC_RSHIFT}) begin
					shift_d = 1'b1;
				end else if (scan_byte == SC_CTRL) begin
					ctrl_d = 1'b1;
				end else if (scan_byte == SC_CAPS) begin
					caps_d = !caps_q;
				end else if (scan_byte == SC_F12) begin
					op.kind = OP_PRESS;
					op.code = KEY_F12;
				end else if (raw_ch != KEY_NONE) begin
					if (ctrl_q) begin
						if (case_ch inside {[ASCII_LA:ASCII_LZ]}) begin
							op.code = case_ch - LOWER_BASE;
						end else if (case_ch inside {[ASCII_UA:ASCII_UZ]}) begin
							op.code = case_ch - UPPER_BASE;
						end
					end else begin
						op.kind = OP_PRESS;
						op.code = case_ch;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= 1'b0;
			ctrl_q   <= 1'b0;
			caps_q   <= 1'b0;
			prefix_q <= 1'b0;
		end else if (push) begin
			shift_q  <= shift_d;
			ctrl_q   <= ctrl_d;
			caps_q   <= caps_d;
			prefix_q <= prefix_d;
		end
	end

endmodule

[design/skm_queue.sv]
// ----------------------------------------------------------------------------
// skm_queue
// Short FIFO of decoded operations between the front and the back.
// ----------------------------------------------------------------------------
module skm_queue import skm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  op_t       push_op,
	input  logic      pop,
	output op_t       head,
	output q_status_t q_stat
);

	op_t                  entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;

	assign head         = entry_q[rd_ptr_q];
	assign q_stat.full  = count_q == (QPTR_BITS + 1)'(QUEUE_DEPTH);
	assign q_stat.empty = count_q == '0;

	function automatic logic [QPTR_BITS-1:0] bump(input logic [QPTR_BITS-1:0] p);
		return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/skm_back.sv]
// ----------------------------------------------------------------------------
// skm_back
// Holds the pressed key and its repeat and release timers, executes one queued
// operation per cycle unless out_stall blocks, registering its key code.
// ----------------------------------------------------------------------------
module skm_back import skm_pkg::*; #(
	parameter int TIME_BITS = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  op_t         head,
	input  q_status_t   q_stat,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  key_code
);

	logic [31:0]          delay_q, period_q, window_q;
	logic [7:0]           held_code_q, held_code_d;
	logic [6:0]           held_scan_q, held_scan_d;
	logic                 held_ext_q, held_ext_d;
	logic [TIME_BITS-1:0] next_rep_q, next_rep_d;
	logic [TIME_BITS-1:0] last_make_q, last_make_d;
	logic [TIME_BITS-1:0] now_t, since_make, since_rep;
	logic [7:0]           result;
	logic                 out_valid_q;
	logic [7:0]           key_code_q;
	logic                 same_key;

	assign pop       = !q_stat.empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign key_code  = key_code_q;

	always_comb begin
		now_t       = TIME_BITS'(head.now);
		since_make  = now_t - last_make_q;
		since_rep   = now_t - next_rep_q;
		same_key    = (held_code_q != KEY_NONE) && (held_ext_q == head.ext) &&
			(held_scan_q == head.scan) && (held_code_q == head.code);
		held_code_d = held_code_q;
		held_scan_d = held_scan_q;
		held_ext_d  = held_ext_q;
		next_rep_d  = next_rep_q;
		last_make_d = last_make_q;
		result      = KEY_NONE;
		case (head.kind)
			OP_POLL: begin
				if (held_code_q != KEY_NONE) begin
					if (!since_make[TIME_BITS-1] && since_make > TIME_BITS'(window_q)) begin
						held_code_d = KEY_NONE;
					end else if (!since_rep[TIME_BITS-1]) begin
						next_rep_d = now_t + TIME_BITS'(period_q);
						result     = held_code_q;
					end
				end
			end
			OP_PRESS: begin
				last_make_d = now_t;
				if (!same_key) begin
					held_code_d = head.code;
					held_scan_d = head.scan;
					held_ext_d  = head.ext;
					next_rep_d  = now_t + TIME_BITS'(delay_q);
					result      = head.code;
				end
			end
			OP_RELEASE: begin
				if (held_ext_q == head.ext && held_scan_q == head.scan) begin
					held_code_d = KEY_NONE;
				end
			end
			default: begin
				result = head.code;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q  <= DELAY_RST;
			period_q <= PERIOD_RST;
			window_q <= WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DELAY:  delay_q  <= cfg_data;
				CFG_PERIOD: period_q <= cfg_data;
				CFG_WINDOW: window_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_code_q <= KEY_NONE;
			held_scan_q <= '0;
			held_ext_q  <= 1'b0;
			next_rep_q  <= '0;
			last_make_q <= '0;
			out_valid_q <= 1'b0;
			key_code_q  <= KEY_NONE;
		end else begin
			if (pop) begin
				held_code_q <= held_code_d;
				held_scan_q <= held_scan_d;
				held_ext_q  <= held_ext_d;
				next_rep_q  <= next_rep_d;
				last_make_q <= last_make_d;
				out_valid_q <= 1'b1;
				key_code_q  <= result;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[tb/scancode_keymap_with_autorepeat_tb.sv]
// ----------------------------------------------------------------------------
// scancode_keymap_with_autorepeat_tb
// Self-checking bench for the set 1 scan code decoder with key auto-repeat.
// A queue-fed driver sends polls, keyboard and aux bytes in random bursts
// while the result side stalls on its own pattern. An in-bench model of the
// decoder tracks modifiers, the E0 prefix and the held key, and each
// key_code is checked in order against it. A short directed run is followed
// by random typing sessions under several repeat and release timings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scancode_keymap_with_autorepeat_tb;
	import skm_pkg::*;

	localparam logic [1:0] REQ_SPARE    = 2'd3;
	localparam logic [7:0] BREAK_FLAG   = 8'h80;
	localparam logic [7:0] NO_SCAN      = 8'h00;
	localparam logic [7:0] NO_CHAR      = 8'h7F;
	localparam int         DRAIN_CYCLES = 8;
	localparam int         PHASE_EVENTS = 305;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  sc;
		logic [47:0] t;
	} key_req_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_TOGGLE
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = REQ_POLL;
	logic [7:0]  scan_byte = NO_SCAN;
	logic [47:0] now = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  key_code;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_DELAY;
	logic [31:0] cfg_data = '0;

	// key maps indexed by scan code, NO_CHAR where nothing is mapped
	string lower_map = {"\177\0331234567890-=\010\t", "qwertyuiop[]\n\177",
		"asdfghjkl;'\140\177\\", "zxcvbnm,./\177*\177 "};
	string upper_map = {"\177\033!@#$%^&*()_+\010\t", "QWERTYUIOP{}\n\177",
		"ASDFGHJKL:\"~\177|", "ZXCVBNM<>?\177*\177 "};

	logic [31:0] rpt_delay = DELAY_RST;
	logic [31:0] rpt_period = PERIOD_RST;
	logic [31:0] rpt_window = WINDOW_RST;
	logic        shift_down = 1'b0;
	logic        ctrl_down = 1'b0;
	logic        caps_on = 1'b0;
	logic        e0_pending = 1'b0;
	logic [7:0]  hold_code = KEY_NONE;
	logic [6:0]  hold_scan = '0;
	logic        hold_ext = 1'b0;
	logic [47:0] repeat_due = '0;
	logic [47:0] make_stamp = '0;

	key_req_t    scan_feed[$];
	logic [7:0]  pending_keys[$];
	int          n_sent = 0;
	int          n_taken = 0;
	int          n_events = 0;
	int          n_fail = 0;
	logic        in_taken = 1'b0;
	int          burst_left = 1;
	int          gap_left = 0;
	rx_mode_t    rx_mode = RX_OPEN;
	int          rx_left = 0;
	logic [47:0] tick = '0;
	int unsigned step_max = 10;

	scancode_keymap_with_autorepeat u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.scan_byte (scan_byte),
		.now       (now),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.key_code  (key_code),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] hold_key(input logic [6:0] k, input logic ext,
			input logic [7:0] c, input logic [47:0] t);
		make_stamp = t;
		if (hold_code != KEY_NONE && hold_ext == ext && hold_scan == k && hold_code == c)
			return KEY_NONE;
		hold_scan = k;
		hold_ext = ext;
		hold_code = c;
		repeat_due = t + {16'h0, rpt_delay};
		return c;
	endfunction

	function automatic logic [7:0] predict_key(input logic [1:0] kind, input logic [7:0] sc,
			input logic [47:0] t);
		logic [7:0]  c;
		logic [6:0]  k;
		logic [47:0] since_make;
		logic [47:0] since_due;
		c = KEY_NONE;
		k = sc[6:0];
		since_make = t - make_stamp;
		since_due = t - repeat_due;
		case (kind)
		REQ_POLL: begin
			if (hold_code != KEY_NONE) begin
				if (!since_make[47] && since_make > {16'h0, rpt_window}) begin
					hold_code = KEY_NONE;
				end else if (!since_due[47]) begin
					repeat_due = t + {16'h0, rpt_period};
					c = hold_code;
				end
			end
		end
		REQ_KEY: begin
			if (e0_pending) begin
				e0_pending = 1'b0;
				if (sc == SC_CTRL) begin
					ctrl_down = 1'b1;
				end else if (sc[7]) begin
					if (sc == SC_CTRL_BRK)
						ctrl_down = 1'b0;
					if (hold_ext && hold_scan == k)
						hold_code = KEY_NONE;
				end else begin
					case (sc)
					SC_UP:    c = shift_down ? KEY_SCRUP : KEY_ARROW_UP;
					SC_DOWN:  c = shift_down ? KEY_SCRDN : KEY_ARROW_DN;
					SC_LEFT:  c = KEY_ARROW_LT;
					SC_RIGHT: c = KEY_ARROW_RT;
					SC_PGUP:  c = KEY_PAGE_UP;
					SC_PGDN:  c = KEY_PAGE_DN;
					SC_HOME:  c = KEY_START;
					SC_END:   c = KEY_END;
					SC_DEL:   c = KEY_DEL;
					default:  c = KEY_NONE;
					endcase
					if (c != KEY_NONE)
						c = hold_key(k, 1'b1, c, t);
				end
			end else if (sc == SC_PREFIX) begin
				e0_pending = 1'b1;
			end else if (sc[7]) begin
				if ({1'b0, k} == SC_LSHIFT || {1'b0, k} == SC_RSHIFT)
					shift_down = 1'b0;
				if ({1'b0, k} == SC_CTRL)
					ctrl_down = 1'b0;
				if (!hold_ext && hold_scan == k)
					hold_code = KEY_NONE;
			end else if (sc == SC_LSHIFT || sc == SC_RSHIFT) begin
				shift_down = 1'b1;
			end else if (sc == SC_CTRL) begin
				ctrl_down = 1'b1;
			end else if (sc == SC_CAPS) begin
				caps_on = !caps_on;
			end else if (sc == SC_F12) begin
				c = hold_key(k, 1'b0, KEY_F12, t);
			end else begin
				if (k < lower_map.len())
					c = shift_down ? upper_map[k] : lower_map[k];
				if (c == NO_CHAR)
					c = KEY_NONE;
				if (caps_on) begin
					if (c >= ASCII_LA && c <= ASCII_LZ)
						c = c - CASE_BIT;
					else if (c >= ASCII_UA && c <= ASCII_UZ)
						c = c + CASE_BIT;
				end
				if (ctrl_down) begin
					if (c >= ASCII_LA && c <= ASCII_LZ)
						c = c - LOWER_BASE;
					else if (c >= ASCII_UA && c <= ASCII_UZ)
						c = c - UPPER_BASE;
					else
						c = KEY_NONE;
				end else if (c != KEY_NONE) begin
					c = hold_key(k, 1'b0, c, t);
				end
			end
		end
		default: c = KEY_NONE;
		endcase
		return c;
	endfunction

	function automatic logic [47:0] advance();
		if ($urandom_range(0, 39) == 0)
			tick = tick + 48'({$urandom, $urandom});
		else
			tick = tick + 48'($urandom_range(0, step_max));
		return tick;
	endfunction

	task automatic queue_req(input logic [1:0] kind, input logic [7:0] sc,
			input logic [47:0] t);
		key_req_t r;
		r.kind = kind;
		r.sc = sc;
		r.t = t;
		scan_feed.push_back(r);
		n_sent++;
		if (kind == REQ_POLL || kind == REQ_KEY)
			n_events++;
	endtask

	task automatic wait_idle();
		while (n_taken != n_sent || pending_keys.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
		CFG_DELAY:  rpt_delay = val;
		CFG_PERIOD: rpt_period = val;
		default:    rpt_window = val;
		endcase
	endtask

	task automatic run_phase(input logic [31:0] d, input logic [31:0] p,
			input logic [31:0] w, input int unsigned step, input logic [47:0] t0);
		int         goal;
		int         n;
		logic       ext;
		logic [7:0] sc;
		wait_idle();
		write_reg(CFG_DELAY, d);
		write_reg(CFG_PERIOD, p);
		write_reg(CFG_WINDOW, w);
		step_max = step;
		tick = t0;
		goal = n_events + PHASE_EVENTS;
		while (n_events < goal) begin
			case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				// press, typematic makes and polls, then usually a break
				ext = ($urandom_range(0, 3) == 0);
				if (ext && $urandom_range(0, 9) != 0) begin
					case ($urandom_range(0, 8))
					0: sc = SC_UP;
					1: sc = SC_DOWN;
					2: sc = SC_LEFT;
					3: sc = SC_RIGHT;
					4: sc = SC_PGUP;
					5: sc = SC_PGDN;
					6: sc = SC_HOME;
					7: sc = SC_END;
					default: sc = SC_DEL;
					endcase
				end else if (!ext && $urandom_range(0, 4) != 0) begin
					sc = 8'($urandom_range(1, 8'h39));
				end else begin
					sc = 8'($urandom_range(0, 127));
				end
				n = $urandom_range(1, 10);
				for (int i = 0; i < n; i++) begin
					if (i == 0 || $urandom_range(0, 2) == 0) begin
						if (ext)
							queue_req(REQ_KEY, SC_PREFIX, advance());
						queue_req(REQ_KEY, sc, advance());
					end else begin
						queue_req(REQ_POLL, NO_SCAN, advance());
					end
				end
				if ($urandom_range(0, 4) != 0) begin
					if (ext)
						queue_req(REQ_KEY, SC_PREFIX, advance());
					queue_req(REQ_KEY, sc | BREAK_FLAG, advance());
				end
			end
			5: begin
				sc = $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
				if ($urandom_range(0, 1))
					sc = sc | BREAK_FLAG;
				queue_req(REQ_KEY, sc, advance());
			end
			6: begin
				if ($urandom_range(0, 1))
					queue_req(REQ_KEY, SC_PREFIX, advance());
				if ($urandom_range(0, 2) == 0)
					queue_req(REQ_KEY, SC_CTRL, advance());
				else if ($urandom_range(0, 1))
					queue_req(REQ_KEY, SC_CTRL_BRK, advance());
				else
					queue_req(REQ_KEY, SC_CAPS, advance());
			end
			7: begin
				repeat ($urandom_range(1, 6)) queue_req(REQ_POLL, NO_SCAN, advance());
			end
			default: begin
				if ($urandom_range(0, 3) == 0)
					queue_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
						48'({$urandom, $urandom}));
				else
					queue_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
						advance());
			end
			endcase
		end
	endtask

	always @(negedge clk) begin : drive
		key_req_t r;
		if (arst_n && (!in_valid || in_taken)) begin
			if (gap_left == 0 && scan_feed.size() != 0) begin
				r = scan_feed.pop_front();
				req_type <= r.kind;
				scan_byte <= r.sc;
				now <= r.t;
				in_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				if (gap_left > 0)
					gap_left--;
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(16, 128);
		end
		rx_left--;
		case (rx_mode)
		RX_OPEN:  out_stall <= 1'b0;
		RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
		RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
		default:  out_stall <= ~out_stall;
		endcase
	end

	always @(posedge clk) begin : watch
		logic [7:0] want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				pending_keys.push_back(predict_key(req_type, scan_byte, now));
				n_taken++;
			end
			if (out_valid && !out_stall) begin
				if (pending_keys.size() == 0) begin
					$display("%0t: key_code expected none, got %02h", $time, key_code);
					n_fail++;
				end else begin
					want = pending_keys.pop_front();
					if (key_code !== want) begin
						$display("%0t: key_code expected %02h, got %02h",
							$time, want, key_code);
						n_fail++;
					end
				end
			end
		end
		in_taken <= arst_n && in_valid && !in_stall;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// default timing: press, refresh, two repeats, then drop on the window
		queue_req(REQ_POLL, NO_SCAN, 48'd0);
		queue_req(REQ_KEY, 8'h1E, 48'd10);
		queue_req(REQ_KEY, 8'h1E, 48'd200000010);
		queue_req(REQ_POLL, NO_SCAN, 48'd385000010);
		queue_req(REQ_POLL, NO_SCAN, 48'd440000010);
		queue_req(REQ_POLL, NO_SCAN, 48'd500000010);
		tick = 48'd500000020;
		queue_req(REQ_KEY, SC_LSHIFT, advance());
		queue_req(REQ_KEY, 8'h02, advance());
		queue_req(REQ_KEY, SC_PREFIX, advance());
		queue_req(REQ_KEY, SC_DOWN, advance());
		queue_req(REQ_KEY, SC_LSHIFT | BREAK_FLAG, advance());
		queue_req(REQ_KEY, SC_CAPS, advance());
		queue_req(REQ_KEY, SC_CTRL, advance());
		queue_req(REQ_KEY, 8'h2E, advance());
		queue_req(REQ_KEY, 8'h02, advance());
		// prefix survives aux bytes and polls
		queue_req(REQ_KEY, SC_PREFIX, advance());
		queue_req(REQ_AUX, 8'hFF, advance());
		queue_req(REQ_POLL, NO_SCAN, advance());
		queue_req(REQ_KEY, SC_CTRL_BRK, advance());
		queue_req(REQ_KEY, SC_PREFIX, advance());
		queue_req(REQ_KEY, SC_PREFIX, advance());
		queue_req(REQ_KEY, SC_PREFIX, advance());
		queue_req(REQ_KEY, SC_CTRL, advance());
		queue_req(REQ_KEY, SC_PREFIX, advance());
		queue_req(REQ_KEY, 8'h37, advance());
		queue_req(REQ_KEY, SC_F12, advance());
		queue_req(REQ_KEY, 8'h7F, advance());
		queue_req(REQ_SPARE, 8'hFF, 48'hFFFF_FFFF_FFFF);
		queue_req(REQ_KEY, SC_CTRL | BREAK_FLAG, advance());

		run_phase(32'd40, 32'd12, 32'd60, 16, 48'hFFFF_FFFF_FF00);
		run_phase(32'd0, 32'd0, 32'd0, 3, 48'({$urandom, $urandom}));
		run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16,
			48'({$urandom, $urandom}));
		run_phase($urandom_range(1, 100), $urandom_range(1, 30), $urandom_range(10, 120),
			12, 48'({$urandom, $urandom}));
		run_phase(32'd5, 32'd1, 32'hFFFF_FFFF, 8, 48'({$urandom, $urandom}));
		run_phase(DELAY_RST, PERIOD_RST, WINDOW_RST, 60000000, 48'({$urandom, $urandom}));
		wait_idle();

		if (n_fail == 0)
			$display("scancode_keymap_with_autorepeat regression: pass");
		else
			$display("scancode_keymap_with_autorepeat regression: fail");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("scancode_keymap_with_autorepeat regression: fail");
		$finish;
	end

endmodule
